@@ design/bos_pkg.sv @@
// ----------------------------------------------------------------------------
// bos_pkg: shared types and constants for box overlap suppression.
// Holds field widths, register indexes, mode codes and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none
package bos_pkg;
    localparam int MAX_BOXES_DEF  = 64;
    localparam int COORD_BITS_DEF = 12;
    localparam int AREA_BITS      = 24;
    localparam int SCORE_BITS     = 16;
    localparam int LIMIT_BITS     = 16;
    localparam int CFG_IDX_BITS   = 8;
    localparam int CFG_DATA_BITS  = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] REG_LIMIT = 8'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_MODE  = 8'd1;

    localparam logic MODE_UNION = 1'b0;
    localparam logic MODE_MIN   = 1'b1;

    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 16'd45875;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_LOAD,
        S_SCAN,
        S_PICK,
        S_TEST,
        S_EMIT
    } t_state;
endpackage
`default_nettype wire

@@ design/bos_ram.sv @@
// ----------------------------------------------------------------------------
// bos_ram: generic single-port-write, single-port-read RAM.
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module bos_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ design/bos_overlap.sv @@
// ----------------------------------------------------------------------------
// bos_overlap: two-stage overlap test of a stored box against the pick.
// Stage one forms the intersection and denominator, stage two compares.
// ----------------------------------------------------------------------------
`default_nettype none
module bos_overlap #(
    parameter int COORD_BITS = bos_pkg::COORD_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic [COORD_BITS-1:0]           i_al,
    input  wire logic [COORD_BITS-1:0]           i_at,
    input  wire logic [COORD_BITS-1:0]           i_ar,
    input  wire logic [COORD_BITS-1:0]           i_ab,
    input  wire logic [bos_pkg::AREA_BITS-1:0]   i_aa,
    input  wire logic [COORD_BITS-1:0]           i_pl,
    input  wire logic [COORD_BITS-1:0]           i_pt,
    input  wire logic [COORD_BITS-1:0]           i_pr,
    input  wire logic [COORD_BITS-1:0]           i_pb,
    input  wire logic [bos_pkg::AREA_BITS-1:0]   i_pa,
    input  wire logic                            i_mode,
    input  wire logic [bos_pkg::LIMIT_BITS-1:0]  i_limit,
    output logic                                 o_hit
);
    localparam int SW = COORD_BITS + 1;
    localparam int IW = 2 * SW;
    localparam int DW = IW + 2;

    logic [COORD_BITS-1:0] lo_x, hi_x, lo_y, hi_y;
    logic signed [SW:0]    wx, wy;
    logic [SW-1:0]         sx, sy;
    logic [IW-1:0]         n_inter, r_inter;
    logic signed [DW-1:0]  n_denom, r_denom;
    logic [DW+16:0]        lhs, rhs;

    // Spans of the intersection, clamped at zero.
    always_comb begin
        lo_x = (i_al > i_pl) ? i_al : i_pl;
        hi_x = (i_ar < i_pr) ? i_ar : i_pr;
        lo_y = (i_at > i_pt) ? i_at : i_pt;
        hi_y = (i_ab < i_pb) ? i_ab : i_pb;
        wx = $signed({2'b00, hi_x}) - $signed({2'b00, lo_x}) + (SW+1)'(1);
        wy = $signed({2'b00, hi_y}) - $signed({2'b00, lo_y}) + (SW+1)'(1);
        sx = (wx > 0) ? wx[SW-1:0] : '0;
        sy = (wy > 0) ? wy[SW-1:0] : '0;
        n_inter = sx * sy;
        if (i_mode == bos_pkg::MODE_MIN) begin
            n_denom = $signed(DW'((i_aa < i_pa) ? i_aa : i_pa));
        end else begin
            n_denom = $signed(DW'(i_aa)) + $signed(DW'(i_pa)) - $signed(DW'(n_inter));
        end
    end

    always_ff @(posedge i_clk) begin
        r_inter <= n_inter;
        r_denom <= n_denom;
    end

    // Threshold compare without division.
    always_comb begin
        lhs = {(DW+17-IW-16)'(0), r_inter, 16'd0};
        rhs = (DW+17)'(i_limit) * (DW+17)'(r_denom[DW-2:0]);
        o_hit = (r_denom <= 0) || (lhs > rhs);
    end
endmodule
`default_nettype wire

@@ design/box_overlap_suppression.sv @@
// ----------------------------------------------------------------------------
// box_overlap_suppression: greedy non-maximum suppression.
// Boxes are loaded into a RAM one per cycle while the input is ready; a final flag starts suppression.
// ----------------------------------------------------------------------------
// Loading accepts boxes while no suppression is running. After the final box,
// each round scans the live boxes through the RAM read port to find the best
// score, fetches the picked entry, then streams every box past the pick through
// the two-stage overlap unit, then presents the kept box until the output takes
// it; rounds repeat until no box is live. Configuration writes are taken only
// between sets, while the store is empty.
`default_nettype none
module box_overlap_suppression #(
    parameter int MAX_BOXES  = bos_pkg::MAX_BOXES_DEF,
    parameter int COORD_BITS = bos_pkg::COORD_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // tdata from bit 0: left, top, right, bottom, box_area, confidence; zero pad
    input  wire logic [((4*COORD_BITS+40+7)/8)*8-1:0] s_axis_tdata,
    input  wire logic                                s_axis_tlast, // final_box
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // tdata from bit 0: kept_left, kept_top, kept_right, kept_bottom,
    // kept_area, kept_confidence; zero pad
    output logic [((4*COORD_BITS+40+7)/8)*8-1:0]     m_axis_tdata,
    output logic                                     m_axis_tlast, // end_of_set
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [bos_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  wire logic [bos_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);
    localparam int CB = COORD_BITS;
    localparam int EW = 4 * CB + 40;
    localparam int TW = ((EW + 7) / 8) * 8;
    localparam int AW = $clog2(MAX_BOXES);
    localparam int NW = $clog2(MAX_BOXES + 1);

    bos_pkg::t_state r_state, n_state;
    logic [bos_pkg::LIMIT_BITS-1:0] r_limit;
    logic r_mode;
    logic [MAX_BOXES-1:0] r_live, n_live;
    logic [NW-1:0] r_count, n_count;
    logic [NW-1:0] r_idx, n_idx;       // read address being issued
    logic [NW-1:0] r_ridx;             // address of data now on the RAM output
    logic r_rvld;
    logic [NW-1:0] r_tidx;             // address of result leaving overlap unit
    logic r_tvld;
    logic [AW-1:0] r_pick, n_pick;
    logic r_found, n_found;
    logic [bos_pkg::SCORE_BITS-1:0] r_best, n_best;
    logic [EW-1:0] r_pbox, n_pbox;
    logic [EW-1:0] rd_data;
    logic [AW-1:0] raddr;
    logic we, hit, out_v, out_last;
    logic [EW-1:0] out_box;
    logic n_out_v;

    // Box store.
    bos_ram #(.WIDTH(EW), .DEPTH(MAX_BOXES)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(r_count[AW-1:0]),
        .i_wdata(s_axis_tdata[EW-1:0]),
        .i_raddr(raddr),
        .o_rdata(rd_data)
    );

    bos_overlap #(.COORD_BITS(CB)) u_ovl (
        .i_clk  (i_clk),
        .i_al   (rd_data[CB-1:0]),
        .i_at   (rd_data[2*CB-1:CB]),
        .i_ar   (rd_data[3*CB-1:2*CB]),
        .i_ab   (rd_data[4*CB-1:3*CB]),
        .i_aa   (rd_data[4*CB+23:4*CB]),
        .i_pl   (r_pbox[CB-1:0]),
        .i_pt   (r_pbox[2*CB-1:CB]),
        .i_pr   (r_pbox[3*CB-1:2*CB]),
        .i_pb   (r_pbox[4*CB-1:3*CB]),
        .i_pa   (r_pbox[4*CB+23:4*CB]),
        .i_mode (r_mode),
        .i_limit(r_limit),
        .o_hit  (hit)
    );

    assign raddr = r_idx[AW-1:0];
    assign s_axis_tready = (r_state == bos_pkg::S_LOAD);
    assign o_cfg_ready = (r_state == bos_pkg::S_LOAD) && (r_count == '0);
    assign we = s_axis_tvalid && s_axis_tready && (r_count < NW'(MAX_BOXES));
    assign m_axis_tvalid = out_v;
    assign m_axis_tdata = TW'(out_box);
    assign m_axis_tlast = out_last;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= bos_pkg::LIMIT_RESET;
            r_mode  <= bos_pkg::MODE_UNION;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == bos_pkg::REG_LIMIT) begin
                r_limit <= i_cfg_data;
            end else if (i_cfg_index == bos_pkg::REG_MODE) begin
                r_mode <= i_cfg_data[0];
            end
        end
    end

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        n_live  = r_live;
        n_count = r_count;
        n_idx   = r_idx;
        n_pick  = r_pick;
        n_found = r_found;
        n_best  = r_best;
        n_pbox  = r_pbox;
        n_out_v = out_v;
        unique case (r_state)
            bos_pkg::S_LOAD: begin
                if (we) begin
                    n_live[r_count[AW-1:0]] = 1'b1;
                    n_count = r_count + NW'(1);
                end
                if (s_axis_tvalid && s_axis_tlast) begin
                    n_idx   = '0;
                    n_found = 1'b0;
                    n_state = bos_pkg::S_SCAN;
                end
            end
            bos_pkg::S_SCAN: begin
                if (r_live == '0) begin
                    n_count = '0;
                    n_state = bos_pkg::S_LOAD;
                end else begin
                    if (r_idx < r_count) begin
                        n_idx = r_idx + NW'(1);
                    end
                    if (r_rvld && r_live[r_ridx[AW-1:0]] &&
                        (!r_found || rd_data[EW-1:EW-16] >= r_best)) begin
                        n_found = 1'b1;
                        n_best  = rd_data[EW-1:EW-16];
                        n_pick  = r_ridx[AW-1:0];
                    end
                    if (!r_rvld && r_idx == r_count) begin
                        n_idx   = NW'(r_pick);
                        n_state = bos_pkg::S_PICK;
                    end
                end
            end
            bos_pkg::S_PICK: begin
                // Wait for the pick's entry, then kill it and start testing.
                if (r_rvld && r_ridx[AW-1:0] == r_pick) begin
                    n_pbox = rd_data;
                    n_live[r_pick] = 1'b0;
                    n_idx = '0;
                    n_state = bos_pkg::S_TEST;
                end
            end
            bos_pkg::S_TEST: begin
                if (r_idx < r_count) begin
                    n_idx = r_idx + NW'(1);
                end
                if (r_tvld && hit) begin
                    n_live[r_tidx[AW-1:0]] = 1'b0;
                end
                if (!r_rvld && !r_tvld && r_idx == r_count) begin
                    n_out_v = 1'b1;
                    n_state = bos_pkg::S_EMIT;
                end
            end
            bos_pkg::S_EMIT: begin
                if (m_axis_tready) begin
                    n_out_v = 1'b0;
                    n_idx   = '0;
                    n_found = 1'b0;
                    n_state = bos_pkg::S_SCAN;
                end
            end
            default: n_state = bos_pkg::S_LOAD;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bos_pkg::S_LOAD;
            r_live  <= '0;
            r_count <= '0;
            r_idx   <= '0;
            r_found <= 1'b0;
            r_rvld  <= 1'b0;
            r_tvld  <= 1'b0;
            out_v   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_live  <= n_live;
            r_count <= n_count;
            r_idx   <= n_idx;
            r_found <= n_found;
            r_rvld  <= ((r_state == bos_pkg::S_SCAN || r_state == bos_pkg::S_TEST) &&
                        r_idx < r_count) || r_state == bos_pkg::S_PICK;
            r_tvld  <= r_rvld && (r_state == bos_pkg::S_TEST);
            out_v   <= n_out_v;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_ridx <= (r_state == bos_pkg::S_PICK) ? NW'(r_pick) : r_idx;
        r_tidx <= r_ridx;
        r_pick <= n_pick;
        r_best <= n_best;
        r_pbox <= n_pbox;
    end

    assign out_box  = r_pbox;
    assign out_last = (r_live == '0);

`ifndef ASSERT_OFF
    a_no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != bos_pkg::S_LOAD) |-> !s_axis_tready)
        else $error("input taken during suppression");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= NW'(MAX_BOXES))
        else $error("box count overflow");
    a_emit_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready) |=> (r_state == bos_pkg::S_SCAN))
        else $error("emit did not return to scan");
    a_pick_gone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !r_live[r_pick])
        else $error("picked box still live");
`endif
endmodule
`default_nettype wire
